// File: sv/slip_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// SLIP frame decoder assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLIP_FRAME_DECODER_DEFINES_SVH
`define SLIP_FRAME_DECODER_DEFINES_SVH

// Condition must hold at every edge outside reset
`define SFD_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("slip_frame_decoder: invariant violated");

// Consequent must hold in the same cycle as the antecedent
`define SFD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slip_frame_decoder: implication violated");

// Consequent must hold in the cycle after the antecedent
`define SFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slip_frame_decoder: next-cycle check violated");

`endif

// File: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Codes, widths and shared types of the SLIP frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

   // SLIP special characters
   localparam logic [7:0] SlipEnd    = 8'hC0;
   localparam logic [7:0] SlipEsc    = 8'hDB;
   localparam logic [7:0] SlipEscEnd = 8'hDC;
   localparam logic [7:0] SlipEscEsc = 8'hDD;

   // Frame length width and largest frame kept
   localparam int unsigned FrameLenW = 13;
   localparam logic [FrameLenW-1:0] MaxFrame = 13'd4096;

   // Per-frame decoder state
   typedef struct packed {
      logic                 escape_pending;
      logic [FrameLenW-1:0] bytes_in_frame;
      logic                 overflowed;
   } sfd_state_type;

   // One result transaction
   typedef struct packed {
      logic [7:0]           data_byte;
      logic                 byte_valid;
      logic                 frame_done;
      logic [FrameLenW-1:0] frame_length;
      logic                 frame_truncated;
      logic                 bad_escape;
   } sfd_result_type;

endpackage

// File: sv/sfd_decode.sv
// ----------------------------------------------------------------------------
// sfd_decode
// Combinational SLIP decode of one line byte against the current frame state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_decode
   import sfd_pkg::*;
(
   input  logic [7:0]           line_byte,
   input  sfd_state_type        state_cur,
   input  logic [FrameLenW-1:0] frame_limit,
   output sfd_state_type        state_nxt,
   output logic                 has_result,
   output sfd_result_type       result
);

   logic       is_end;
   logic       is_esc;
   logic [7:0] mapped_byte;
   logic       bad;
   logic       room;

   assign is_end = (line_byte == SlipEnd);
   assign is_esc = (line_byte == SlipEsc);
   assign room   = (state_cur.bytes_in_frame < frame_limit);

   // Map the escaped byte and flag unknown escape sequences
   always_comb begin
      mapped_byte = line_byte;
      bad         = 1'b0;
      if (state_cur.escape_pending) begin
         if (line_byte == SlipEscEnd) begin
            mapped_byte = SlipEnd;
         end else if (line_byte == SlipEscEsc) begin
            mapped_byte = SlipEsc;
         end else begin
            bad = 1'b1;
         end
      end
   end

   // Advance frame state and build the result transaction
   always_comb begin
      state_nxt  = state_cur;
      has_result = 1'b0;
      result     = '0;
      if (is_end) begin
         // close a nonempty frame, skip an empty one; escape flag is kept
         if (state_cur.bytes_in_frame != '0) begin
            has_result             = 1'b1;
            result.frame_done      = 1'b1;
            result.frame_length    = state_cur.bytes_in_frame;
            result.frame_truncated = state_cur.overflowed;
            state_nxt.bytes_in_frame = '0;
            state_nxt.overflowed     = 1'b0;
         end
      end else if (!state_cur.escape_pending && is_esc) begin
         state_nxt.escape_pending = 1'b1;
      end else begin
         state_nxt.escape_pending = 1'b0;
         if (room) begin
            has_result               = 1'b1;
            result.data_byte         = mapped_byte;
            result.byte_valid        = 1'b1;
            result.bad_escape        = bad;
            state_nxt.bytes_in_frame = state_cur.bytes_in_frame + FrameLenW'(1);
         end else begin
            // drop the byte; report only a bad escape
            state_nxt.overflowed = 1'b1;
            has_result           = bad;
            result.bad_escape    = bad;
         end
      end
   end

endmodule

// File: sv/sfd_out_buf.sv
// ----------------------------------------------------------------------------
// sfd_out_buf
// Two-entry result register with skid stage between decoder and rsp channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_out_buf
   import sfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sfd_result_type push_data,
   output logic           full,
   output logic           out_valid,
   output sfd_result_type out_data,
   input  logic           out_stall
);

   logic           main_valid_ff;
   logic           main_valid_in;
   logic           skid_valid_ff;
   logic           skid_valid_in;
   sfd_result_type main_ff;
   sfd_result_type main_in;
   sfd_result_type skid_ff;
   sfd_result_type skid_in;
   logic           pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Refill main from skid, else from a new push (to skid if main is held), else clear main on a pop
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// File: sv/slip_frame_decoder.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder
// Result path: a taken byte's result is registered in the main output entry, or in the skid entry when main is held.
// Throughput: 1 byte per cycle while req_stall is low; req_stall rises only when both output entries fill.
// Reset: synchronous; clears escape, count and overflow and sets the limit to 4096.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slip_frame_decoder_defines.svh"

module slip_frame_decoder
   import sfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [FrameLenW-1:0] csr_max_frame_bytes,
   // received line bytes
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_line_byte,
   // decoded results
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_frame_done,
   output logic [FrameLenW-1:0] rsp_frame_length,
   output logic                 rsp_frame_truncated,
   output logic                 rsp_bad_escape
);

   logic [FrameLenW-1:0] frame_limit_ff;
   logic [FrameLenW-1:0] frame_limit_in;
   sfd_state_type        state_ff;
   sfd_state_type        state_nxt;
   logic                 req_accept;
   logic                 has_result;
   sfd_result_type       dec_result;
   sfd_result_type       rsp_result;
   logic                 buf_full;

   assign csr_ready  = 1'b1;
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   // Clamp the written limit into one to the largest frame
   always_comb begin
      frame_limit_in = frame_limit_ff;
      if (csr_valid && csr_ready) begin
         if (csr_max_frame_bytes == '0) begin
            frame_limit_in = FrameLenW'(1);
         end else if (csr_max_frame_bytes > MaxFrame) begin
            frame_limit_in = MaxFrame;
         end else begin
            frame_limit_in = csr_max_frame_bytes;
         end
      end
   end

   sfd_decode u_decode (
      .line_byte   (req_line_byte),
      .state_cur   (state_ff),
      .frame_limit (frame_limit_ff),
      .state_nxt   (state_nxt),
      .has_result  (has_result),
      .result      (dec_result)
   );

   // Hold limit and frame state; advance state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= MaxFrame;
         state_ff       <= '0;
      end else begin
         frame_limit_ff <= frame_limit_in;
         if (req_accept) begin
            state_ff <= state_nxt;
         end
      end
   end

   sfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && has_result),
      .push_data (dec_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_result),
      .out_stall (rsp_stall)
   );

   assign rsp_data_byte       = rsp_result.data_byte;
   assign rsp_byte_valid      = rsp_result.byte_valid;
   assign rsp_frame_done      = rsp_result.frame_done;
   assign rsp_frame_length    = rsp_result.frame_length;
   assign rsp_frame_truncated = rsp_result.frame_truncated;
   assign rsp_bad_escape      = rsp_result.bad_escape;

   // Check count bound, result shape, buffer order and frame close
   `SFD_ASSERT_ALWAYS(a_count_bound, state_ff.bytes_in_frame <= MaxFrame)
   `SFD_ASSERT_IMPLY(a_result_kind, rsp_valid, !(rsp_byte_valid && rsp_frame_done))
   `SFD_ASSERT_IMPLY(a_skid_order, req_stall, rsp_valid)
   `SFD_ASSERT_NEXT(a_end_clears, req_accept && req_line_byte == SlipEnd,
                    state_ff.bytes_in_frame == '0 && !state_ff.overflowed)

endmodule
